// ===== hdl/flow_table_packet_counter_macros.svh =====
// assertion macros shared by the flow table modules
// expects clk and rst_n in the scope of each use
`ifndef FLOW_TABLE_PACKET_COUNTER_MACROS_SVH
`define FLOW_TABLE_PACKET_COUNTER_MACROS_SVH

// same-cycle implication
`define FTPC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FTPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ftpc_pkg.sv =====
// types and constants of the flow table packet counter
// no dependencies
package ftpc_pkg;

    localparam logic [15:0] ETH_IPV4  = 16'h0800;
    localparam logic [15:0] ETH_IPV6  = 16'h86DD;
    localparam logic [7:0]  PROTO_TCP = 8'd6;
    localparam logic [7:0]  PROTO_UDP = 8'd17;

    localparam logic [2:0] ST_NOT_IP   = 3'd0;
    localparam logic [2:0] ST_NOT_L4   = 3'd1;
    localparam logic [2:0] ST_HIT      = 3'd2;
    localparam logic [2:0] ST_NEW_FLOW = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    typedef struct packed {
        logic [63:0] src_hi;
        logic [63:0] src_lo;
        logic [63:0] dst_hi;
        logic [63:0] dst_lo;
        logic [31:0] ports;
        logic [8:0]  kind;    // {is_ipv6, protocol}
    } flow_key_t;

    typedef struct packed {
        logic       capture;
        logic       issue;
        logic       hit_write;
        logic       append;
        logic       res_load;
        logic [2:0] res_code;
        logic       out_load;
    } ftpc_cmd_t;

    typedef struct packed {
        logic in_is_ip;
        logic in_is_l4;
        logic match;
        logic cmp_vld;
        logic scan_more;
        logic full;
        logic out_busy;
    } ftpc_stat_t;

endpackage

// ===== hdl/ftpc_ctrl.sv =====
// controller of the flow table: accept, key scan, result hand-off
// depends on ftpc_pkg and the assertion macro header
`include "flow_table_packet_counter_macros.svh"

module ftpc_ctrl
    import ftpc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pkt_valid,
    output logic       pkt_ready,
    input  ftpc_stat_t stat,
    output ftpc_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_REPORT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pkt_ready  = 1'b0;
        cmd        = '0;
        cmd.res_code = ST_NOT_IP;
        unique case (state_reg)
            S_IDLE:
            begin
                pkt_ready = 1'b1;
                if (pkt_valid)
                begin
                    cmd.capture = 1'b1;
                    if (!stat.in_is_ip)
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_code = ST_NOT_IP;
                        state_next   = S_REPORT;
                    end
                    else if (!stat.in_is_l4)
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_code = ST_NOT_L4;
                        state_next   = S_REPORT;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // key reads are registered and run ahead of the compare
                if (stat.match)
                begin
                    cmd.hit_write = 1'b1;
                    cmd.res_load  = 1'b1;
                    cmd.res_code  = ST_HIT;
                    state_next    = S_REPORT;
                end
                else if (stat.scan_more)
                begin
                    cmd.issue = 1'b1;
                end
                else if (!stat.cmp_vld)
                begin
                    cmd.res_load = 1'b1;
                    if (stat.full)
                    begin
                        cmd.res_code = ST_FULL;
                    end
                    else
                    begin
                        cmd.append   = 1'b1;
                        cmd.res_code = ST_NEW_FLOW;
                    end
                    state_next = S_REPORT;
                end
            end
            S_REPORT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `FTPC_ASSERT_NEXT(a_accept_leaves_idle, pkt_valid && pkt_ready, state_reg != S_IDLE, "accepted request did not start work")
    `FTPC_ASSERT_NEXT(a_match_reports, state_reg == S_SCAN && stat.match, state_reg == S_REPORT, "flow hit not reported next")
    `FTPC_ASSERT_NEXT(a_report_done, state_reg == S_REPORT && !stat.out_busy, state_reg == S_IDLE, "result hand-off stuck")

endmodule

// ===== hdl/ftpc_datapath.sv =====
// datapath of the flow table: key and count memories, totals, result register
// depends on ftpc_pkg and the assertion macro header
`include "flow_table_packet_counter_macros.svh"

module ftpc_datapath
    import ftpc_pkg::*;
#(
    parameter int FLOW_ENTRIES = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  ftpc_cmd_t   cmd,
    output ftpc_stat_t  stat,
    input  logic [15:0] eth_type,
    input  logic [7:0]  protocol,
    input  logic [63:0] src_addr_hi,
    input  logic [63:0] src_addr_lo,
    input  logic [63:0] dst_addr_hi,
    input  logic [63:0] dst_addr_lo,
    input  logic [15:0] source_port,
    input  logic [15:0] dest_port,
    input  logic [15:0] frame_len,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [2:0]  status,
    output logic [7:0]  flow_index,
    output logic [31:0] flow_count,
    output logic [31:0] packet_total,
    output logic [31:0] tcp_packets,
    output logic [31:0] udp_packets,
    output logic [63:0] tcp_byte_total,
    output logic [63:0] udp_byte_total,
    output logic [8:0]  flow_total,
    output logic [8:0]  tcp_flow_total,
    output logic [8:0]  udp_flow_total
);

    localparam int CNT_W = $clog2(FLOW_ENTRIES + 1);
    localparam int IDX_W = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
    localparam logic [CNT_W-1:0] ENTRIES_MAX = CNT_W'(FLOW_ENTRIES);

    flow_key_t   key_mem [FLOW_ENTRIES];
    logic [31:0] cnt_mem [FLOW_ENTRIES];

    flow_key_t        key_reg;
    flow_key_t        key_rd_reg;
    logic [31:0]      cnt_rd_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic             cmp_vld_reg;
    logic [CNT_W-1:0] scan_cnt_reg;
    logic [CNT_W-1:0] used_reg;
    logic [CNT_W-1:0] tcp_made_reg;
    logic [CNT_W-1:0] udp_made_reg;
    logic [31:0]      pkts_reg;
    logic [31:0]      tcp_pkts_reg;
    logic [31:0]      udp_pkts_reg;
    logic [63:0]      tcp_octets_reg;
    logic [63:0]      udp_octets_reg;
    logic [2:0]       res_status_reg;
    logic [IDX_W-1:0] res_idx_reg;
    logic [31:0]      res_cnt_reg;
    logic             out_valid_reg;

    logic             in_v6;
    logic             in_tcp;
    logic             in_udp;
    flow_key_t        in_key;
    logic             match;
    logic [IDX_W-1:0] scan_idx;
    logic [IDX_W-1:0] used_idx;
    logic [31:0]      hit_cnt;

    assign in_v6  = (eth_type == ETH_IPV6);
    assign in_tcp = (protocol == PROTO_TCP);
    assign in_udp = (protocol == PROTO_UDP);

    // ipv4 keeps only the low 32 bits of each address
    always_comb
    begin
        in_key.src_hi = in_v6 ? src_addr_hi : 64'd0;
        in_key.dst_hi = in_v6 ? dst_addr_hi : 64'd0;
        in_key.src_lo = in_v6 ? src_addr_lo : {32'd0, src_addr_lo[31:0]};
        in_key.dst_lo = in_v6 ? dst_addr_lo : {32'd0, dst_addr_lo[31:0]};
        in_key.ports  = {source_port, dest_port};
        in_key.kind   = {in_v6, protocol};
    end

    assign scan_idx = scan_cnt_reg[IDX_W-1:0];
    assign used_idx = used_reg[IDX_W-1:0];
    assign match    = cmp_vld_reg && (key_rd_reg == key_reg);
    assign hit_cnt  = cnt_rd_reg + 32'd1;

    always_comb
    begin
        stat.in_is_ip  = (eth_type == ETH_IPV4) || in_v6;
        stat.in_is_l4  = in_tcp || in_udp;
        stat.match     = match;
        stat.cmp_vld   = cmp_vld_reg;
        stat.scan_more = (scan_cnt_reg < used_reg);
        stat.full      = (used_reg >= ENTRIES_MAX);
        stat.out_busy  = out_valid_reg && !res_ready;
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            key_rd_reg <= key_mem[scan_idx];
            cnt_rd_reg <= cnt_mem[scan_idx];
        end
        if (cmd.append)
        begin
            key_mem[used_idx] <= key_reg;
        end
        if (cmd.hit_write)
        begin
            cnt_mem[cmp_idx_reg] <= hit_cnt;
        end
        else if (cmd.append)
        begin
            cnt_mem[used_idx] <= 32'd1;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            key_reg <= in_key;
        end
        if (cmd.issue)
        begin
            cmp_idx_reg <= scan_idx;
        end
        if (cmd.res_load)
        begin
            res_status_reg <= cmd.res_code;
            unique case (cmd.res_code)
                ST_HIT:
                begin
                    res_idx_reg <= cmp_idx_reg;
                    res_cnt_reg <= hit_cnt;
                end
                ST_NEW_FLOW:
                begin
                    res_idx_reg <= used_idx;
                    res_cnt_reg <= 32'd1;
                end
                default:
                begin
                    res_idx_reg <= '0;
                    res_cnt_reg <= 32'd0;
                end
            endcase
        end
        if (cmd.out_load)
        begin
            status         <= res_status_reg;
            flow_index     <= 8'(res_idx_reg);
            flow_count     <= res_cnt_reg;
            packet_total   <= pkts_reg;
            tcp_packets    <= tcp_pkts_reg;
            udp_packets    <= udp_pkts_reg;
            tcp_byte_total <= tcp_octets_reg;
            udp_byte_total <= udp_octets_reg;
            flow_total     <= 9'(used_reg);
            tcp_flow_total <= 9'(tcp_made_reg);
            udp_flow_total <= 9'(udp_made_reg);
        end
    end

    // counters and control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_vld_reg    <= 1'b0;
            scan_cnt_reg   <= '0;
            used_reg       <= '0;
            tcp_made_reg   <= '0;
            udp_made_reg   <= '0;
            pkts_reg       <= 32'd0;
            tcp_pkts_reg   <= 32'd0;
            udp_pkts_reg   <= 32'd0;
            tcp_octets_reg <= 64'd0;
            udp_octets_reg <= 64'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cmp_vld_reg <= cmd.issue;
            if (cmd.capture)
            begin
                scan_cnt_reg <= '0;
                pkts_reg     <= pkts_reg + 32'd1;
                if (stat.in_is_ip && in_tcp)
                begin
                    tcp_pkts_reg   <= tcp_pkts_reg + 32'd1;
                    tcp_octets_reg <= tcp_octets_reg + {48'd0, frame_len};
                end
                if (stat.in_is_ip && in_udp)
                begin
                    udp_pkts_reg   <= udp_pkts_reg + 32'd1;
                    udp_octets_reg <= udp_octets_reg + {48'd0, frame_len};
                end
            end
            else if (cmd.issue)
            begin
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
            end
            if (cmd.append)
            begin
                used_reg <= used_reg + 1'b1;
                if (key_reg.kind[7:0] == PROTO_TCP)
                begin
                    tcp_made_reg <= tcp_made_reg + 1'b1;
                end
                else
                begin
                    udp_made_reg <= udp_made_reg + 1'b1;
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign res_valid = out_valid_reg;

    `FTPC_ASSERT_SAME(a_append_not_full, cmd.append, used_reg < ENTRIES_MAX, "append when full")
    `FTPC_ASSERT_SAME(a_hit_in_range, match, CNT_W'(cmp_idx_reg) < used_reg, "hit on unused entry")
    `FTPC_ASSERT_SAME(a_load_when_free, cmd.out_load, !out_valid_reg || res_ready, "result lost")
    `FTPC_ASSERT_NEXT(a_append_counts, cmd.append, used_reg == $past(used_reg) + 1'b1, "count stuck")

endmodule

// ===== hdl/flow_table_packet_counter.sv =====
// top level of the flow table packet counter
// depends on ftpc_pkg, ftpc_ctrl and ftpc_datapath
//
//  channel   handshake               payload
//  request   pkt_valid / pkt_ready   eth_type .. frame_len
//  result    res_valid / res_ready   status .. udp_flow_total
//
// a tcp/udp miss steps through accept, a key read of each stored entry, the compare of the
// last read, the decision and the report; a hit on entry i ends the scan at its compare
// other requests go from accept straight to the report
// reset clears all counters; the tables hold no valid bits and need no clearing
// a waiting result is held in the output register while the next request is accepted
module flow_table_packet_counter
    import ftpc_pkg::*;
#(
    parameter int FLOW_ENTRIES = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pkt_valid,
    output logic        pkt_ready,
    input  logic [15:0] eth_type,
    input  logic [7:0]  protocol,
    input  logic [63:0] src_addr_hi,
    input  logic [63:0] src_addr_lo,
    input  logic [63:0] dst_addr_hi,
    input  logic [63:0] dst_addr_lo,
    input  logic [15:0] source_port,
    input  logic [15:0] dest_port,
    input  logic [15:0] frame_len,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [2:0]  status,
    output logic [7:0]  flow_index,
    output logic [31:0] flow_count,
    output logic [31:0] packet_total,
    output logic [31:0] tcp_packets,
    output logic [31:0] udp_packets,
    output logic [63:0] tcp_byte_total,
    output logic [63:0] udp_byte_total,
    output logic [8:0]  flow_total,
    output logic [8:0]  tcp_flow_total,
    output logic [8:0]  udp_flow_total
);

    ftpc_cmd_t  cmd;
    ftpc_stat_t stat;

    ftpc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt_valid (pkt_valid),
        .pkt_ready (pkt_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ftpc_datapath #(
        .FLOW_ENTRIES (FLOW_ENTRIES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .eth_type       (eth_type),
        .protocol       (protocol),
        .src_addr_hi    (src_addr_hi),
        .src_addr_lo    (src_addr_lo),
        .dst_addr_hi    (dst_addr_hi),
        .dst_addr_lo    (dst_addr_lo),
        .source_port    (source_port),
        .dest_port      (dest_port),
        .frame_len      (frame_len),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .status         (status),
        .flow_index     (flow_index),
        .flow_count     (flow_count),
        .packet_total   (packet_total),
        .tcp_packets    (tcp_packets),
        .udp_packets    (udp_packets),
        .tcp_byte_total (tcp_byte_total),
        .udp_byte_total (udp_byte_total),
        .flow_total     (flow_total),
        .tcp_flow_total (tcp_flow_total),
        .udp_flow_total (udp_flow_total)
    );

endmodule
